@@ hdl/tgdg_pkg.sv @@
// shared constants and register map for the tone generator
package tgdg_pkg;

    // field widths
    localparam int CLK_W    = 24;
    localparam int DIV_W    = 8;
    localparam int FREQ_W   = 16;
    localparam int STEP_W   = 16;
    localparam int CMP_W    = 13;
    localparam int CNT_W    = 5;
    localparam int ADDR_W   = 4;
    localparam int DATA_W   = 32;

    // serial divider step counts
    localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(CLK_W - 1);
    localparam logic [CNT_W-1:0] DEC_LAST  = CNT_W'(FREQ_W - 1);
    localparam logic [4:0]       DEC_BASE  = 5'd10;

    // register reset values
    localparam logic [CLK_W-1:0] CLK_HZ_RST   = CLK_W'(1250000);
    localparam logic [DIV_W-1:0] TICK_DIV_RST = DIV_W'(8);

    // request codes
    typedef enum logic {
        REQ_PLAY = 1'b0,
        REQ_TICK = 1'b1
    } req_t;

    // register byte addresses
    typedef enum logic [ADDR_W-1:0] {
        ADDR_CLK_HZ   = 4'h0,
        ADDR_TICK_DIV = 4'h4,
        ADDR_ENABLE   = 4'h8
    } reg_addr_t;

endpackage

@@ hdl/tone_generator_duration_gap.sv @@
// buzzer tone scheduler with serial period divider, duration and gap timers
//
// Each input transaction is either a play request or a timer tick, and each one
// yields exactly one output transaction carrying the current pwm period and
// compare values, the busy flag and the request flags. A tick, and a play
// request that arrives while a tone or gap is still running, finish in the cycle
// they are taken, so their result is ready in the next cycle. A play request taken
// while idle runs the bit-serial divider: it forms tone_clock_hz / frequency one
// quotient bit a cycle, then period / 10 one bit a cycle (a zero frequency skips
// the first divider). Only one transaction is in work at a time; the next one
// is taken as soon as the previous result has left or leaves in that same cycle.
// A zero frequency, or a quotient above 16 bits, gives period 65535 and raises
// bad_frequency. Ticks are divided by tick_divide before a countdown step; with
// enable low the prescaler still runs up to its limit and holds there. Registers
// sit on the apb port at byte offsets 0 (tone_clock_hz), 4 (tick_divide) and
// 8 (enable) and should be written only while idle.
module tone_generator_duration_gap (
    input  logic                            clk,
    input  logic                            rst_n,
    // input channel
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            req_type,
    input  logic [tgdg_pkg::FREQ_W-1:0]     frequency,
    input  logic [tgdg_pkg::STEP_W-1:0]     duration,
    input  logic [tgdg_pkg::STEP_W-1:0]     gap,
    // output channel
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [tgdg_pkg::FREQ_W-1:0]     tone_period,
    output logic [tgdg_pkg::CMP_W-1:0]      tone_compare,
    output logic                            busy_res,
    output logic                            accepted,
    output logic                            restart_timer,
    output logic                            bad_frequency,
    // configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [tgdg_pkg::ADDR_W-1:0]     paddr,
    input  logic [tgdg_pkg::DATA_W-1:0]     pwdata,
    output logic [tgdg_pkg::DATA_W-1:0]     prdata,
    output logic                            pready
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_DEC
    } state_t;

    state_t                          state_reg, state_next;
    logic [tgdg_pkg::CNT_W-1:0]      cnt_reg, cnt_next;

    // configuration registers
    logic [tgdg_pkg::CLK_W-1:0]      clk_hz_reg;
    logic [tgdg_pkg::DIV_W-1:0]      tick_div_reg;
    logic                            enable_reg;

    // scheduler state
    logic                            active_reg, active_next;
    logic [tgdg_pkg::STEP_W-1:0]     dur_reg, dur_next;
    logic [tgdg_pkg::STEP_W-1:0]     gap_reg, gap_next;
    logic [tgdg_pkg::FREQ_W-1:0]     period_reg, period_next;
    logic [tgdg_pkg::CMP_W-1:0]      compare_reg, compare_next;
    logic [tgdg_pkg::DIV_W-1:0]      prescale_reg, prescale_next;

    // serial divider datapath
    logic [tgdg_pkg::FREQ_W-1:0]     divisor_reg, divisor_next;
    logic [tgdg_pkg::CLK_W-1:0]      dvd_reg, dvd_next;
    logic [tgdg_pkg::FREQ_W-1:0]     rem_reg, rem_next;
    logic [tgdg_pkg::FREQ_W-1:0]     dec_reg, dec_next;
    logic [3:0]                      dec_rem_reg, dec_rem_next;
    logic [tgdg_pkg::FREQ_W-1:0]     pcalc_reg, pcalc_next;
    logic                            bad_reg, bad_next;

    // output register
    logic                            ovalid_reg, ovalid_next;
    logic [tgdg_pkg::FREQ_W-1:0]     operiod_reg, operiod_next;
    logic [tgdg_pkg::CMP_W-1:0]      ocompare_reg, ocompare_next;
    logic                            obusy_reg, obusy_next;
    logic                            oacc_reg, oacc_next;
    logic                            obad_reg, obad_next;

    logic                            in_acc;
    logic                            out_acc;
    logic                            cfg_wr;
    logic [tgdg_pkg::FREQ_W:0]       trial;
    logic [tgdg_pkg::FREQ_W+1:0]     diff;
    logic                            q_bit;
    logic [tgdg_pkg::CLK_W-1:0]      quot;
    logic                            sat;
    logic [4:0]                      dec_trial;
    logic                            dec_bit;
    logic                            step;

    assign out_acc  = ovalid_reg && !out_stall;
    // one transaction in work; the result slot must be free or draining
    assign in_stall = (state_reg != ST_IDLE) || (ovalid_reg && out_stall);
    assign in_acc   = in_valid && !in_stall;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign pready   = 1'b1;

    // register readback
    always_comb
    begin
        case (paddr)
            tgdg_pkg::ADDR_CLK_HZ:   prdata = tgdg_pkg::DATA_W'(clk_hz_reg);
            tgdg_pkg::ADDR_TICK_DIV: prdata = tgdg_pkg::DATA_W'(tick_div_reg);
            tgdg_pkg::ADDR_ENABLE:   prdata = tgdg_pkg::DATA_W'(enable_reg);
            default:                 prdata = '0;
        endcase
    end

    // one restoring divide step: remainder shifted left with next dividend bit
    assign trial = {rem_reg, dvd_reg[tgdg_pkg::CLK_W-1]};
    assign diff  = {1'b0, trial} - {2'b00, divisor_reg};
    assign q_bit = !diff[tgdg_pkg::FREQ_W+1];
    assign quot  = {dvd_reg[tgdg_pkg::CLK_W-2:0], q_bit};
    assign sat   = |quot[tgdg_pkg::CLK_W-1:tgdg_pkg::FREQ_W];

    // divide by ten, one quotient bit per cycle
    assign dec_trial = {dec_rem_reg, dec_reg[tgdg_pkg::FREQ_W-1]};
    assign dec_bit   = (dec_trial >= tgdg_pkg::DEC_BASE);

    // prescaler fires a countdown step on this tick
    assign step = enable_reg && (prescale_reg >= tick_div_reg);

    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        active_next   = active_reg;
        dur_next      = dur_reg;
        gap_next      = gap_reg;
        period_next   = period_reg;
        compare_next  = compare_reg;
        prescale_next = prescale_reg;
        divisor_next  = divisor_reg;
        dvd_next      = dvd_reg;
        rem_next      = rem_reg;
        dec_next      = dec_reg;
        dec_rem_next  = dec_rem_reg;
        pcalc_next    = pcalc_reg;
        bad_next      = bad_reg;
        ovalid_next   = ovalid_reg && !out_acc;
        operiod_next  = operiod_reg;
        ocompare_next = ocompare_reg;
        obusy_next    = obusy_reg;
        oacc_next     = oacc_reg;
        obad_next     = obad_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    if (req_type == tgdg_pkg::REQ_PLAY && !active_reg)
                    begin
                        // take the request, period computed serially
                        active_next  = 1'b1;
                        dur_next     = duration;
                        gap_next     = (gap == '0) ? tgdg_pkg::STEP_W'(1) : gap;
                        divisor_next = frequency;
                        dvd_next     = clk_hz_reg;
                        rem_next     = '0;
                        dec_rem_next = '0;
                        cnt_next     = '0;
                        if (frequency == '0)
                        begin
                            pcalc_next = '1;
                            dec_next   = '1;
                            bad_next   = 1'b1;
                            state_next = ST_DEC;
                        end
                        else
                        begin
                            bad_next   = 1'b0;
                            state_next = ST_DIV;
                        end
                    end
                    else
                    begin
                        if (req_type == tgdg_pkg::REQ_TICK)
                        begin
                            if (step)
                            begin
                                prescale_next = '0;
                                if (active_reg)
                                begin
                                    if (dur_reg != '0)
                                    begin
                                        dur_next = dur_reg - tgdg_pkg::STEP_W'(1);
                                    end
                                    else
                                    begin
                                        period_next  = '0;
                                        compare_next = '0;
                                    end
                                    if (dur_next == '0)
                                    begin
                                        if (gap_reg != '0)
                                        begin
                                            gap_next = gap_reg - tgdg_pkg::STEP_W'(1);
                                        end
                                        else
                                        begin
                                            active_next = 1'b0;
                                        end
                                    end
                                end
                            end
                            if (prescale_next < tick_div_reg)
                            begin
                                prescale_next = prescale_next + tgdg_pkg::DIV_W'(1);
                            end
                        end
                        // ticks and busy requests answer at once
                        ovalid_next   = 1'b1;
                        operiod_next  = period_next;
                        ocompare_next = compare_next;
                        obusy_next    = active_next;
                        oacc_next     = 1'b0;
                        obad_next     = 1'b0;
                    end
                end
            end
            ST_DIV:
            begin
                dvd_next = quot;
                rem_next = q_bit ? diff[tgdg_pkg::FREQ_W-1:0]
                                 : trial[tgdg_pkg::FREQ_W-1:0];
                cnt_next = cnt_reg + tgdg_pkg::CNT_W'(1);
                if (cnt_reg == tgdg_pkg::DIV_LAST)
                begin
                    pcalc_next = sat ? '1 : quot[tgdg_pkg::FREQ_W-1:0];
                    dec_next   = sat ? '1 : quot[tgdg_pkg::FREQ_W-1:0];
                    bad_next   = sat;
                    cnt_next   = '0;
                    state_next = ST_DEC;
                end
            end
            ST_DEC:
            begin
                dec_next     = {dec_reg[tgdg_pkg::FREQ_W-2:0], dec_bit};
                dec_rem_next = dec_bit ? 4'(dec_trial - tgdg_pkg::DEC_BASE)
                                       : dec_trial[3:0];
                cnt_next     = cnt_reg + tgdg_pkg::CNT_W'(1);
                if (cnt_reg == tgdg_pkg::DEC_LAST)
                begin
                    // commit tone and present the result
                    period_next   = pcalc_reg;
                    compare_next  = dec_next[tgdg_pkg::CMP_W-1:0];
                    ovalid_next   = 1'b1;
                    operiod_next  = pcalc_reg;
                    ocompare_next = dec_next[tgdg_pkg::CMP_W-1:0];
                    obusy_next    = active_reg;
                    oacc_next     = 1'b1;
                    obad_next     = bad_reg;
                    cnt_next      = '0;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            clk_hz_reg   <= tgdg_pkg::CLK_HZ_RST;
            tick_div_reg <= tgdg_pkg::TICK_DIV_RST;
            enable_reg   <= 1'b1;
            active_reg   <= 1'b0;
            dur_reg      <= '0;
            gap_reg      <= '0;
            period_reg   <= '0;
            compare_reg  <= '0;
            prescale_reg <= '0;
            divisor_reg  <= '0;
            dvd_reg      <= '0;
            rem_reg      <= '0;
            dec_reg      <= '0;
            dec_rem_reg  <= '0;
            pcalc_reg    <= '0;
            bad_reg      <= 1'b0;
            ovalid_reg   <= 1'b0;
            operiod_reg  <= '0;
            ocompare_reg <= '0;
            obusy_reg    <= 1'b0;
            oacc_reg     <= 1'b0;
            obad_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            active_reg   <= active_next;
            dur_reg      <= dur_next;
            gap_reg      <= gap_next;
            period_reg   <= period_next;
            compare_reg  <= compare_next;
            prescale_reg <= prescale_next;
            divisor_reg  <= divisor_next;
            dvd_reg      <= dvd_next;
            rem_reg      <= rem_next;
            dec_reg      <= dec_next;
            dec_rem_reg  <= dec_rem_next;
            pcalc_reg    <= pcalc_next;
            bad_reg      <= bad_next;
            ovalid_reg   <= ovalid_next;
            operiod_reg  <= operiod_next;
            ocompare_reg <= ocompare_next;
            obusy_reg    <= obusy_next;
            oacc_reg     <= oacc_next;
            obad_reg     <= obad_next;
            if (cfg_wr)
            begin
                case (paddr)
                    tgdg_pkg::ADDR_CLK_HZ:   clk_hz_reg   <= pwdata[tgdg_pkg::CLK_W-1:0];
                    tgdg_pkg::ADDR_TICK_DIV: tick_div_reg <= pwdata[tgdg_pkg::DIV_W-1:0];
                    tgdg_pkg::ADDR_ENABLE:   enable_reg   <= pwdata[0];
                    default:                 ;
                endcase
            end
        end
    end

    assign out_valid     = ovalid_reg;
    assign tone_period   = operiod_reg;
    assign tone_compare  = ocompare_reg;
    assign busy_res      = obusy_reg;
    assign accepted      = oacc_reg;
    assign restart_timer = oacc_reg;
    assign bad_frequency = obad_reg;

    // a play request taken while idle starts the serial divider
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && req_type == tgdg_pkg::REQ_PLAY && !active_reg)
            |=> (state_reg == ST_DIV || state_reg == ST_DEC))
        else $error("play request did not start the divider");

    // the result slot is empty while the divider runs
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !ovalid_reg)
        else $error("result pending during division");

    // compare never exceeds period
    assert property (@(posedge clk) disable iff (!rst_n)
        (tgdg_pkg::FREQ_W'(compare_reg) <= period_reg))
        else $error("compare above period");

    // an idle scheduler has both timers spent
    assert property (@(posedge clk) disable iff (!rst_n)
        !active_reg |-> (dur_reg == '0 && gap_reg == '0))
        else $error("timers left over while idle");

    // a taken request always reports busy
    assert property (@(posedge clk) disable iff (!rst_n)
        (ovalid_reg && oacc_reg) |-> obusy_reg)
        else $error("accepted request not busy");

endmodule
